>>> rtl/bsb_pkg.sv
package bsb_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int AW           = $clog2(MAX_VERTICES);
    localparam int CNTW         = AW + 1;
    localparam int DIR_COUNT    = 13;
    localparam int DIRW         = $clog2(DIR_COUNT);

    localparam int CW   = 16;
    localparam int VW   = 3 * CW;
    localparam int PJW  = 19;
    localparam int SUMW = CW + 1;
    localparam int OW   = 24;
    localparam int CTW  = 25;
    localparam int PDW  = 26;
    localparam int MW   = 27;
    localparam int ACCW = 50;
    localparam int RW   = 26;

    localparam int SQW      = 50;
    localparam int SQ_STEPS = SQW / 2;
    localparam int SQ_REMW  = SQ_STEPS + 2;

    localparam int NW  = 50;
    localparam int DVW = RW + 1;
    localparam int QW  = 25;

    localparam logic [1:0] DIR_POS = 2'b01;
    localparam logic [1:0] DIR_NEG = 2'b11;

    typedef struct packed {
        logic           start;
        logic [SQW-1:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic          done;
        logic [RW-1:0] root;
    } sqrt_rsp_t;

    typedef struct packed {
        logic           start;
        logic [NW-1:0]  dividend;
        logic [DVW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic          done;
        logic [QW-1:0] quotient;
    } div_rsp_t;

    // direction components packed as {z, y, x}
    function automatic logic [5:0] dir_vec(input logic [DIRW-1:0] j);
        logic [5:0] v;
        case (j)
            4'd0:    v = {2'b00, 2'b00, DIR_POS};
            4'd1:    v = {2'b00, DIR_POS, 2'b00};
            4'd2:    v = {DIR_POS, 2'b00, 2'b00};
            4'd3:    v = {2'b00, DIR_POS, DIR_POS};
            4'd4:    v = {DIR_POS, 2'b00, DIR_POS};
            4'd5:    v = {DIR_POS, DIR_POS, 2'b00};
            4'd6:    v = {2'b00, DIR_NEG, DIR_POS};
            4'd7:    v = {DIR_NEG, 2'b00, DIR_POS};
            4'd8:    v = {DIR_NEG, DIR_POS, 2'b00};
            4'd9:    v = {DIR_POS, DIR_POS, DIR_POS};
            4'd10:   v = {DIR_POS, DIR_NEG, DIR_POS};
            4'd11:   v = {DIR_NEG, DIR_POS, DIR_POS};
            4'd12:   v = {DIR_NEG, DIR_NEG, DIR_POS};
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/bsb_ram.sv
module bsb_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/bsb_sqrt.sv
module bsb_sqrt import bsb_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  sqrt_req_t req,
    output sqrt_rsp_t rsp
);

    localparam int CNT_W = $clog2(SQ_STEPS + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SQW-1:0]      rad_reg, rad_next;
    logic [SQ_REMW-1:0]  rem_reg, rem_next;
    logic [SQ_STEPS-1:0] root_reg, root_next;

    logic [SQ_REMW+1:0]  rem_sh;
    logic [SQ_REMW+1:0]  trial;

    always_comb
    begin
        rem_sh    = {rem_reg, rad_reg[SQW-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(SQ_STEPS);
            rad_next  = req.radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[SQW-3:0], 2'b00};
            cnt_next = cnt_reg - CNT_W'(1);
            if (rem_sh >= trial)
            begin
                rem_next  = SQ_REMW'(rem_sh - trial);
                root_next = {root_reg[SQ_STEPS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = SQ_REMW'(rem_sh);
                root_next = {root_reg[SQ_STEPS-2:0], 1'b0};
            end
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    // rounded up
    assign rsp.done = done_reg;
    assign rsp.root = RW'(root_reg) + RW'(rem_reg != '0);

endmodule

>>> rtl/bsb_div.sv
module bsb_div import bsb_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(QW + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [QW-1:0]    num_reg, num_next;
    logic [DVW-1:0]   rem_reg, rem_next;
    logic [DVW-1:0]   den_reg, den_next;
    logic [QW-1:0]    quo_reg, quo_next;

    logic [DVW:0]     rs;

    always_comb
    begin
        rs        = {rem_reg, num_reg[QW-1]};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QW);
            num_next  = req.dividend[QW-1:0];
            rem_next  = DVW'(req.dividend[NW-1:QW]);
            den_next  = req.divisor;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[QW-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (rs >= {1'b0, den_reg})
            begin
                rem_next = DVW'(rs - {1'b0, den_reg});
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = DVW'(rs);
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

>>> rtl/bounding_sphere_builder.sv
// bounding sphere builder
// input channel (in_valid / in_stall): one vertex per transfer, signed 16-bit
// x, y, z; last_vertex closes the set. while loading, one vertex is taken
// every cycle and written to the 1024-entry vertex memory; the 13 direction
// extremes update in the same cycle. vertices past 1024 are dropped and flag
// overflowed.
// after the last vertex in_stall stays high while the sphere is built:
// seed: one pass over the 13 direction extremes plus a 25-step square
// root; then one memory read per stored vertex, and for a vertex outside
// the sphere also a square root and three 25-step divisions. the
// multiplier is shared and the square root and divider are serial.
// output channel (out_valid / out_stall): one result per set, held in an
// output register until transferred; loading of the next set may start while
// it waits. a finished result waits for the register to free up.
// reset clears the vertex count, the overflow flag and the output valid.
module bounding_sphere_builder import bsb_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [CW-1:0] vertex_x,
    input  logic signed [CW-1:0] vertex_y,
    input  logic signed [CW-1:0] vertex_z,
    input  logic                 last_vertex,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [OW-1:0] center_x,
    output logic signed [OW-1:0] center_y,
    output logic signed [OW-1:0] center_z,
    output logic        [OW-1:0] radius,
    output logic                 overflowed
);

    localparam logic [4:0] ST_IDLE      = 5'd0;
    localparam logic [4:0] ST_SP_RDA    = 5'd1;
    localparam logic [4:0] ST_SP_RDB    = 5'd2;
    localparam logic [4:0] ST_SP_DIFF   = 5'd3;
    localparam logic [4:0] ST_SQ        = 5'd4;
    localparam logic [4:0] ST_SP_CMP    = 5'd5;
    localparam logic [4:0] ST_SEED      = 5'd6;
    localparam logic [4:0] ST_SEED_WAIT = 5'd7;
    localparam logic [4:0] ST_G_RD      = 5'd8;
    localparam logic [4:0] ST_G_WAIT    = 5'd9;
    localparam logic [4:0] ST_RR        = 5'd10;
    localparam logic [4:0] ST_RR_CMP    = 5'd11;
    localparam logic [4:0] ST_G_SQRT    = 5'd12;
    localparam logic [4:0] ST_MV_MUL    = 5'd13;
    localparam logic [4:0] ST_MV_DIV    = 5'd14;
    localparam logic [4:0] ST_MV_WAIT   = 5'd15;
    localparam logic [4:0] ST_DONE      = 5'd16;

    logic [4:0]      state_reg, state_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic            ovf_reg, ovf_next;
    logic            out_valid_reg, out_valid_next;
    logic [DIRW-1:0] j_reg, j_next;
    logic [1:0]      k_reg, k_next;
    logic [CNTW-1:0] i_reg, i_next;
    logic            grow_reg, grow_next;

    logic signed [PJW-1:0]  pmin_reg [DIR_COUNT];
    logic signed [PJW-1:0]  pmin_next [DIR_COUNT];
    logic signed [PJW-1:0]  pmax_reg [DIR_COUNT];
    logic signed [PJW-1:0]  pmax_next [DIR_COUNT];
    logic        [AW-1:0]   imin_reg [DIR_COUNT];
    logic        [AW-1:0]   imin_next [DIR_COUNT];
    logic        [AW-1:0]   imax_reg [DIR_COUNT];
    logic        [AW-1:0]   imax_next [DIR_COUNT];
    logic signed [PJW-1:0]  proj [DIR_COUNT];

    logic signed [CW-1:0]   va_reg [3];
    logic signed [CW-1:0]   va_next [3];
    logic signed [SUMW-1:0] sum_reg [3];
    logic signed [SUMW-1:0] sum_next [3];
    logic signed [SUMW-1:0] bsum_reg [3];
    logic signed [SUMW-1:0] bsum_next [3];
    logic signed [PDW-1:0]  d_reg [3];
    logic signed [PDW-1:0]  d_next [3];
    logic signed [CTW-1:0]  c_reg [3];
    logic signed [CTW-1:0]  c_next [3];
    logic        [ACCW-1:0] best_reg, best_next;
    logic        [ACCW-1:0] acc_reg, acc_next;
    logic        [ACCW-1:0] prod_reg;
    logic        [RW-1:0]   r_reg, r_next;
    logic        [RW-1:0]   dist_reg, dist_next;

    logic signed [OW-1:0]   cx_reg, cx_next;
    logic signed [OW-1:0]   cy_reg, cy_next;
    logic signed [OW-1:0]   cz_reg, cz_next;
    logic        [OW-1:0]   rad_reg, rad_next;
    logic                   ovo_reg, ovo_next;

    logic signed [MW-1:0]   mul_a, mul_b;
    logic signed [2*MW-1:0] mul_p;

    logic                   ram_we;
    logic [AW-1:0]          ram_raddr;
    logic [VW-1:0]          ram_rdata;
    logic signed [CW-1:0]   rd_c [3];

    sqrt_req_t sq_req;
    sqrt_rsp_t sq_rsp;
    div_req_t  dv_req;
    div_rsp_t  dv_rsp;

    function automatic logic signed [PJW-1:0] dir_term(input logic [1:0] c,
                                                       input logic signed [CW-1:0] v);
        logic signed [PJW-1:0] t;
        case (c)
            DIR_POS: t = PJW'(v);
            DIR_NEG: t = -PJW'(v);
            default: t = '0;
        endcase
        return t;
    endfunction

    bsb_ram #(
        .WIDTH(VW),
        .DEPTH(MAX_VERTICES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata ({vertex_z, vertex_y, vertex_x}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bsb_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sq_req),
        .rsp   (sq_rsp)
    );

    bsb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dv_req),
        .rsp   (dv_rsp)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign mul_p    = mul_a * mul_b;

    always_comb
    begin
        logic [5:0] dv;
        for (int j = 0; j < DIR_COUNT; j++)
        begin
            dv      = dir_vec(DIRW'(j));
            proj[j] = dir_term(dv[1:0], vertex_x) + dir_term(dv[3:2], vertex_y)
                    + dir_term(dv[5:4], vertex_z);
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            rd_c[k] = ram_rdata[k*CW +: CW];
        end
    end

    always_comb
    begin
        logic signed [PDW-1:0] sq_op;
        logic        [PDW-1:0] mag;
        logic        [RW-1:0]  gap;
        logic        [RW:0]    rsum;
        logic signed [CTW-1:0] q;

        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        grow_next      = grow_reg;
        pmin_next      = pmin_reg;
        pmax_next      = pmax_reg;
        imin_next      = imin_reg;
        imax_next      = imax_reg;
        va_next        = va_reg;
        sum_next       = sum_reg;
        bsum_next      = bsum_reg;
        d_next         = d_reg;
        c_next         = c_reg;
        best_next      = best_reg;
        acc_next       = acc_reg;
        r_next         = r_reg;
        dist_next      = dist_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cz_next        = cz_reg;
        rad_next       = rad_reg;
        ovo_next       = ovo_reg;
        ram_we         = 1'b0;
        ram_raddr      = '0;
        mul_a          = '0;
        mul_b          = '0;
        sq_req         = '0;
        dv_req         = '0;

        case (k_reg)
            2'd0:    sq_op = d_reg[0];
            2'd1:    sq_op = d_reg[1];
            default: sq_op = d_reg[2];
        endcase
        mag  = sq_op[PDW-1] ? PDW'(-sq_op) : PDW'(sq_op);
        gap  = dist_reg - r_reg;
        rsum = {1'b0, r_reg} + {1'b0, dist_reg} + (RW+1)'(1);
        q    = CTW'({1'b0, dv_rsp.quotient});

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (count_reg < CNTW'(MAX_VERTICES))
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CNTW'(1);
                        for (int j = 0; j < DIR_COUNT; j++)
                        begin
                            if (count_reg == '0)
                            begin
                                pmin_next[j] = proj[j];
                                pmax_next[j] = proj[j];
                                imin_next[j] = '0;
                                imax_next[j] = '0;
                            end
                            else if (proj[j] < pmin_reg[j])
                            begin
                                pmin_next[j] = proj[j];
                                imin_next[j] = count_reg[AW-1:0];
                            end
                            else if (proj[j] > pmax_reg[j])
                            begin
                                pmax_next[j] = proj[j];
                                imax_next[j] = count_reg[AW-1:0];
                            end
                        end
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_vertex)
                    begin
                        j_next     = '0;
                        state_next = ST_SP_RDA;
                    end
                end
            end
            ST_SP_RDA:
            begin
                ram_raddr  = imax_reg[j_reg];
                state_next = ST_SP_RDB;
            end
            ST_SP_RDB:
            begin
                ram_raddr  = imin_reg[j_reg];
                va_next    = rd_c;
                state_next = ST_SP_DIFF;
            end
            ST_SP_DIFF:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    d_next[k]   = PDW'(SUMW'(va_reg[k]) - SUMW'(rd_c[k]));
                    sum_next[k] = SUMW'(va_reg[k]) + SUMW'(rd_c[k]);
                end
                acc_next   = '0;
                k_next     = '0;
                grow_next  = 1'b0;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                mul_a = MW'(sq_op);
                mul_b = MW'(sq_op);
                if (k_reg != 2'd0)
                begin
                    acc_next = acc_reg + prod_reg;
                end
                if (k_reg == 2'd3)
                begin
                    state_next = grow_reg ? ST_RR : ST_SP_CMP;
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                end
            end
            ST_SP_CMP:
            begin
                if (j_reg == '0 || acc_reg > best_reg)
                begin
                    best_next = acc_reg;
                    bsum_next = sum_reg;
                end
                if (j_reg == DIRW'(DIR_COUNT - 1))
                begin
                    state_next = ST_SEED;
                end
                else
                begin
                    j_next     = j_reg + DIRW'(1);
                    state_next = ST_SP_RDA;
                end
            end
            ST_SEED:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    c_next[k] = CTW'($signed({bsum_reg[k], 7'b0}));
                end
                sq_req.start    = 1'b1;
                sq_req.radicand = {best_reg[SQW-17:0], 16'b0};
                state_next      = ST_SEED_WAIT;
            end
            ST_SEED_WAIT:
            begin
                if (sq_rsp.done)
                begin
                    rsum       = {1'b0, sq_rsp.root} + (RW+1)'(1);
                    r_next     = rsum[RW:1];
                    i_next     = '0;
                    state_next = ST_G_RD;
                end
            end
            ST_G_RD:
            begin
                if (i_reg == count_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ram_raddr  = i_reg[AW-1:0];
                    state_next = ST_G_WAIT;
                end
            end
            ST_G_WAIT:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    d_next[k] = PDW'($signed({rd_c[k], 8'b0})) - PDW'(c_reg[k]);
                end
                acc_next   = '0;
                k_next     = '0;
                grow_next  = 1'b1;
                state_next = ST_SQ;
            end
            ST_RR:
            begin
                mul_a      = $signed({1'b0, r_reg});
                mul_b      = $signed({1'b0, r_reg});
                state_next = ST_RR_CMP;
            end
            ST_RR_CMP:
            begin
                if (acc_reg > prod_reg)
                begin
                    sq_req.start    = 1'b1;
                    sq_req.radicand = acc_reg[SQW-1:0];
                    state_next      = ST_G_SQRT;
                end
                else
                begin
                    i_next     = i_reg + CNTW'(1);
                    state_next = ST_G_RD;
                end
            end
            ST_G_SQRT:
            begin
                if (sq_rsp.done)
                begin
                    dist_next  = sq_rsp.root;
                    k_next     = '0;
                    state_next = ST_MV_MUL;
                end
            end
            ST_MV_MUL:
            begin
                mul_a      = $signed({1'b0, mag});
                mul_b      = $signed({1'b0, gap});
                state_next = ST_MV_DIV;
            end
            ST_MV_DIV:
            begin
                dv_req.start    = 1'b1;
                dv_req.dividend = prod_reg[NW-1:0];
                dv_req.divisor  = {dist_reg, 1'b0};
                state_next      = ST_MV_WAIT;
            end
            ST_MV_WAIT:
            begin
                if (dv_rsp.done)
                begin
                    if (sq_op[PDW-1])
                    begin
                        c_next[k_reg] = c_reg[k_reg] - q;
                    end
                    else
                    begin
                        c_next[k_reg] = c_reg[k_reg] + q;
                    end
                    if (k_reg == 2'd2)
                    begin
                        r_next     = rsum[RW:1];
                        i_next     = i_reg + CNTW'(1);
                        state_next = ST_G_RD;
                    end
                    else
                    begin
                        k_next     = k_reg + 2'd1;
                        state_next = ST_MV_MUL;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cx_next        = c_reg[0][OW-1:0];
                    cy_next        = c_reg[1][OW-1:0];
                    cz_next        = c_reg[2][OW-1:0];
                    rad_next       = (r_reg > RW'({OW{1'b1}})) ? {OW{1'b1}} : r_reg[OW-1:0];
                    ovo_next       = ovf_reg;
                    out_valid_next = 1'b1;
                    count_next     = '0;
                    ovf_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            j_reg         <= '0;
            k_reg         <= '0;
            i_reg         <= '0;
            grow_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            i_reg         <= i_next;
            grow_reg      <= grow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pmin_reg <= pmin_next;
        pmax_reg <= pmax_next;
        imin_reg <= imin_next;
        imax_reg <= imax_next;
        va_reg   <= va_next;
        sum_reg  <= sum_next;
        bsum_reg <= bsum_next;
        d_reg    <= d_next;
        c_reg    <= c_next;
        best_reg <= best_next;
        acc_reg  <= acc_next;
        prod_reg <= mul_p[ACCW-1:0];
        r_reg    <= r_next;
        dist_reg <= dist_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        cz_reg   <= cz_next;
        rad_reg  <= rad_next;
        ovo_reg  <= ovo_next;
    end

    assign out_valid  = out_valid_reg;
    assign center_x   = cx_reg;
    assign center_y   = cy_reg;
    assign center_z   = cz_reg;
    assign radius     = rad_reg;
    assign overflowed = ovo_reg;

endmodule

>>> rtl/bsb_checker.sv
module bsb_checker import bsb_pkg::*; (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic signed [CW-1:0] vertex_x,
    input logic signed [CW-1:0] vertex_y,
    input logic signed [CW-1:0] vertex_z,
    input logic                 last_vertex,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic signed [OW-1:0] center_x,
    input logic signed [OW-1:0] center_y,
    input logic signed [OW-1:0] center_z,
    input logic        [OW-1:0] radius,
    input logic                 overflowed
);

    // a stalled result keeps its transfer pending
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(center_x) && $stable(center_y)
            && $stable(center_z) && $stable(radius) && $stable(overflowed))
        else $error("stalled result changed");

    // closing a set starts the build, which blocks further vertices
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_vertex |=> in_stall)
        else $error("vertex taken while building");

    // a result only appears at the end of a build
    a_rose_from_build: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without build");

endmodule

bind bounding_sphere_builder bsb_checker u_bsb_checker (.*);

>>> tb/testbench.sv
module testbench;
    import bsb_pkg::*;

    typedef struct {
        logic [OW-1:0] cx;
        logic [OW-1:0] cy;
        logic [OW-1:0] cz;
        logic [OW-1:0] rad;
        logic          ovf;
    } sphere_t;

    class sphere_scoreboard;
        int dirs[13][3] = '{
            '{1, 0, 0}, '{0, 1, 0}, '{0, 0, 1},
            '{1, 1, 0}, '{1, 0, 1}, '{0, 1, 1},
            '{1, -1, 0}, '{1, 0, -1}, '{0, 1, -1},
            '{1, 1, 1}, '{1, -1, 1}, '{1, 1, -1},
            '{1, -1, -1}
        };
        int store[MAX_VERTICES][3];
        int count;
        bit ovf_seen;
        int pmin[13], pmax[13], imin[13], imax[13];
        sphere_t spheres[$];
        int errors;
        int sets_done;
        int overflow_sets;

        function longint unsigned isqrt(longint unsigned n);
            longint unsigned r, bitv;
            r = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv >>= 2;
            while (bitv != 0)
            begin
                if (n >= r + bitv)
                begin
                    n -= r + bitv;
                    r = (r >> 1) + bitv;
                end
                else
                    r >>= 1;
                bitv >>= 2;
            end
            return r;
        endfunction

        function longint unsigned isqrt_up(longint unsigned n);
            longint unsigned s;
            s = isqrt(n);
            if (s * s < n) s++;
            return s;
        endfunction

        function longint unsigned span(int a, int b);
            longint unsigned sum;
            longint signed d;
            sum = 0;
            for (int k = 0; k < 3; k++)
            begin
                d = longint'(store[a][k]) - longint'(store[b][k]);
                sum += longint'(d * d);
            end
            return sum;
        endfunction

        function void build();
            longint signed c[3], p[3], mv;
            longint unsigned best, m2, r, reach, gap, mag;
            int pick, a, b;
            sphere_t s;
            best = span(imax[0], imin[0]);
            pick = 0;
            for (int j = 1; j < 13; j++)
            begin
                m2 = span(imax[j], imin[j]);
                if (m2 > best)
                begin
                    best = m2;
                    pick = j;
                end
            end
            a = imin[pick];
            b = imax[pick];
            for (int k = 0; k < 3; k++)
                c[k] = (longint'(store[a][k]) + longint'(store[b][k])) * 128;
            r = (isqrt_up(best << 16) + 1) >> 1;
            for (int i = 0; i < count; i++)
            begin
                m2 = 0;
                for (int k = 0; k < 3; k++)
                begin
                    p[k] = longint'(store[i][k]) * 256 - c[k];
                    m2 += p[k] * p[k];
                end
                if (m2 > r * r)
                begin
                    reach = isqrt_up(m2);
                    gap = reach - r;
                    for (int k = 0; k < 3; k++)
                    begin
                        mag = (p[k] < 0) ? -p[k] : p[k];
                        mv = (mag * gap) / (2 * reach);
                        c[k] += (p[k] < 0) ? -mv : mv;
                    end
                    r = (r + reach + 1) >> 1;
                end
            end
            s.cx = c[0][OW-1:0];
            s.cy = c[1][OW-1:0];
            s.cz = c[2][OW-1:0];
            s.rad = (r > 64'hFFFFFF) ? 24'hFFFFFF : r[OW-1:0];
            s.ovf = ovf_seen;
            spheres.push_back(s);
        endfunction

        function void note_vertex(int x, int y, int z, bit last);
            int d;
            if (count < MAX_VERTICES)
            begin
                store[count][0] = x;
                store[count][1] = y;
                store[count][2] = z;
                for (int j = 0; j < 13; j++)
                begin
                    d = dirs[j][0] * x + dirs[j][1] * y + dirs[j][2] * z;
                    if (count == 0)
                    begin
                        pmin[j] = d;
                        pmax[j] = d;
                        imin[j] = 0;
                        imax[j] = 0;
                    end
                    else if (d < pmin[j])
                    begin
                        pmin[j] = d;
                        imin[j] = count;
                    end
                    else if (d > pmax[j])
                    begin
                        pmax[j] = d;
                        imax[j] = count;
                    end
                end
                count++;
            end
            else
                ovf_seen = 1;
            if (last)
            begin
                build();
                sets_done++;
                if (ovf_seen) overflow_sets++;
                count = 0;
                ovf_seen = 0;
            end
        endfunction

        function void check_sphere(logic [OW-1:0] cx, logic [OW-1:0] cy,
                                   logic [OW-1:0] cz, logic [OW-1:0] rad, logic ovf);
            sphere_t e;
            if (spheres.size() == 0)
            begin
                $error("unexpected result center %h %h %h radius %h", cx, cy, cz, rad);
                errors++;
                return;
            end
            e = spheres.pop_front();
            if (cx !== e.cx)
            begin
                $error("center_x expected %h actual %h", e.cx, cx);
                errors++;
            end
            if (cy !== e.cy)
            begin
                $error("center_y expected %h actual %h", e.cy, cy);
                errors++;
            end
            if (cz !== e.cz)
            begin
                $error("center_z expected %h actual %h", e.cz, cz);
                errors++;
            end
            if (rad !== e.rad)
            begin
                $error("radius expected %h actual %h", e.rad, rad);
                errors++;
            end
            if (ovf !== e.ovf)
            begin
                $error("overflowed expected %b actual %b", e.ovf, ovf);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    logic signed [CW-1:0] vertex_x = '0;
    logic signed [CW-1:0] vertex_y = '0;
    logic signed [CW-1:0] vertex_z = '0;
    logic last_vertex = 0;
    logic out_valid;
    logic out_stall = 0;
    logic signed [OW-1:0] center_x, center_y, center_z;
    logic [OW-1:0] radius;
    logic overflowed;

    sphere_scoreboard sb = new();
    int burst_left = 0;
    int vertices_sent = 0;

    bounding_sphere_builder uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z),
        .last_vertex(last_vertex),
        .out_valid(out_valid), .out_stall(out_stall),
        .center_x(center_x), .center_y(center_y), .center_z(center_z),
        .radius(radius), .overflowed(overflowed)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_sphere(center_x, center_y, center_z, radius, overflowed);
    end

    // receiver stall pattern, with one long hold
    initial
    begin
        int mode;
        int left;
        int hold_left;
        bit held;
        mode = 0;
        left = 0;
        hold_left = 0;
        held = 0;
        forever
        begin
            @(negedge clk);
            if (!held && vertices_sent >= 1300)
            begin
                held = 1;
                hold_left = 3000;
            end
            if (hold_left > 0)
            begin
                out_stall = 1;
                hold_left--;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(20, 400);
                end
                left--;
                case (mode)
                    0: out_stall = 0;
                    1: out_stall = ($urandom_range(0, 3) == 0);
                    2: out_stall = ($urandom_range(0, 1) == 0);
                    default: out_stall = ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    task automatic send_vertex(int x, int y, int z, bit last);
        if (burst_left == 0)
        begin
            in_valid = 0;
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(negedge clk);
            burst_left = $urandom_range(1, 30);
        end
        in_valid = 1;
        vertex_x = CW'(x);
        vertex_y = CW'(y);
        vertex_z = CW'(z);
        last_vertex = last;
        do @(posedge clk); while (in_stall);
        sb.note_vertex(x, y, z, last);
        vertices_sent++;
        @(negedge clk);
        burst_left--;
    endtask

    function automatic int pick_coord(int mode);
        case (mode)
            0: return $signed(16'($urandom));
            1: return $urandom_range(0, 200) - 100;
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return -32768;
                    1: return 32767;
                    2: return 0;
                    default: return -1;
                endcase
            end
            default: return $urandom_range(0, 8000) - 4000;
        endcase
    endfunction

    task automatic send_set(int n, int mode);
        for (int i = 0; i < n; i++)
            send_vertex(pick_coord(mode), pick_coord(mode), pick_coord(mode), i == n - 1);
    endtask

    initial
    begin
        int set_no;
        int n;
        repeat (10) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        send_vertex(32767, 32767, 32767, 1);
        send_vertex(-32768, -32768, -32768, 0);
        send_vertex(32767, 32767, 32767, 1);
        send_vertex(0, 0, 0, 0);
        send_vertex(0, 0, 0, 0);
        send_vertex(0, 0, 0, 1);
        send_vertex(-32768, 0, 0, 0);
        send_vertex(32767, 0, 0, 0);
        send_vertex(0, 32767, 0, 0);
        send_vertex(0, -32768, 32767, 0);
        send_vertex(0, 0, -32768, 1);
        send_vertex(32767, -32768, 0, 0);
        send_vertex(-32768, 32767, -1, 1);
        send_vertex(5, 5, 5, 0);
        send_vertex(5, 5, 5, 0);
        send_vertex(-5, -5, -5, 0);
        send_vertex(-5, -5, -5, 1);

        set_no = 0;
        while (vertices_sent < 1600)
        begin
            if (set_no == 6)
                send_set(MAX_VERTICES + 2, 3);
            else
            begin
                if (set_no == 25)
                begin
                    in_valid = 0;
                    while (sb.spheres.size() > 0) @(negedge clk);
                end
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 50)
                                                : $urandom_range(1, 10);
                send_set(n, $urandom_range(0, 3));
            end
            set_no++;
        end
        in_valid = 0;
        last_vertex = 0;

        while (sb.spheres.size() > 0) @(negedge clk);
        repeat (300) @(negedge clk);
        $display("%0d vertices in %0d sets, %0d sets past the store size",
                 vertices_sent, sb.sets_done, sb.overflow_sets);
        if (sb.errors == 0 && sb.spheres.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #(8 * 3000000);
        $display("FAILED: results differ");
        $finish;
    end
endmodule

>>> bounding_sphere_builder.f
rtl/bsb_pkg.sv
rtl/bsb_ram.sv
rtl/bsb_sqrt.sv
rtl/bsb_div.sv
rtl/bounding_sphere_builder.sv
rtl/bsb_checker.sv
tb/testbench.sv
